/* src/smap_pkg.sv */
`timescale 1ns / 1ps

package smap_pkg;

    // Result status codes
    localparam logic [1:0] STATUS_FOUND      = 2'd0;
    localparam logic [1:0] STATUS_NONE       = 2'd1;
    localparam logic [1:0] STATUS_HDR_REJECT = 2'd2;
    localparam logic [1:0] STATUS_LEN_ERROR  = 2'd3;

    // Configuration register indexes (word address bits)
    localparam logic [1:0] REG_TXID_HIGH = 2'd0;
    localparam logic [1:0] REG_TXID_MID  = 2'd1;
    localparam logic [1:0] REG_TXID_LOW  = 2'd2;

    // Protocol constants
    localparam logic [31:0] MAGIC_COOKIE     = 32'h2112A442;
    localparam logic [15:0] ATTR_XOR_MAPPED  = 16'h0020;
    localparam logic [15:0] ATTR_XOR_MAPPED2 = 16'h8020;
    localparam logic [7:0]  TYPE_BYTE        = 8'h01;
    localparam logic [7:0]  FAMILY_IPV4      = 8'h01;
    localparam int          HEADER_BYTES     = 20;
    localparam logic [15:0] MIN_ADDR_LEN     = 16'd8;

    // Byte counter width and saturation value
    localparam int            COUNT_W   = 17;
    localparam logic [16:0]   COUNT_MAX = 17'h1FFFF;

    // Attribute offsets are one bit wider than the byte counter
    localparam int POS_W = 18;

endpackage

/* src/stun_mapped_address_parser.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// rx        in         rx_valid / rx_stall   rx_byte, last_flag
// res       out        res_valid / res_stall status, mapped_address, mapped_port
// apb       in         psel/penable/pready   paddr, pwdata, pwrite, prdata
//
// One byte is accepted per cycle while rx_stall is low; every byte is parsed in the cycle it is taken.
// The result beat is registered and shows in the cycle after the byte with last_flag.
// rx_stall is high only while a result beat waits and res_stall holds it.
// Reset clears the parse state and the transaction id registers.
// After each last byte the parse state returns to its reset values.

module stun_mapped_address_parser
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    input  logic        last_flag,

    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  status,
    output logic [31:0] mapped_address,
    output logic [15:0] mapped_port,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = smap_pkg::COUNT_W;
    localparam int PW = smap_pkg::POS_W;

    // Configuration registers
    logic [31:0] txid_high_reg;
    logic [31:0] txid_mid_reg;
    logic [31:0] txid_low_reg;

    // Parse state
    logic [CW-1:0] count_reg,      count_next;
    logic          hdr_good_reg,   hdr_good_next;
    logic [15:0]   msg_len_reg,    msg_len_next;
    logic [PW-1:0] next_start_reg, next_start_next;
    logic [15:0]   attr_type_reg,  attr_type_next;
    logic [15:0]   attr_len_reg,   attr_len_next;
    logic [PW-1:0] last_end_reg,   last_end_next;
    logic          match_reg,      match_next;
    logic [7:0]    family_reg,     family_next;
    logic [15:0]   port_reg,       port_next;
    logic [31:0]   addr_reg,       addr_next;

    // Result register
    logic          res_valid_reg;
    logic [1:0]    status_reg,     status_next;
    logic [31:0]   map_addr_reg,   map_addr_next;
    logic [15:0]   map_port_reg,   map_port_next;

    logic rx_accept;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Skid: hold input only while a result beat is stuck
    assign rx_stall  = res_valid_reg && res_stall;
    assign rx_accept = rx_valid && !rx_stall;

    assign res_valid      = res_valid_reg;
    assign status         = status_reg;
    assign mapped_address = map_addr_reg;
    assign mapped_port    = map_port_reg;

    // Register read
    always_comb
    begin
        unique case (paddr[3:2])
            smap_pkg::REG_TXID_HIGH: prdata = txid_high_reg;
            smap_pkg::REG_TXID_MID:  prdata = txid_mid_reg;
            smap_pkg::REG_TXID_LOW:  prdata = txid_low_reg;
            default:                 prdata = 32'd0;
        endcase
    end

    // Register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            txid_high_reg <= 32'd0;
            txid_mid_reg  <= 32'd0;
            txid_low_reg  <= 32'd0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                smap_pkg::REG_TXID_HIGH: txid_high_reg <= pwdata;
                smap_pkg::REG_TXID_MID:  txid_mid_reg  <= pwdata;
                smap_pkg::REG_TXID_LOW:  txid_low_reg  <= pwdata;
                default:                 ;
            endcase
        end
    end

    // Expected header byte at the current position
    logic [4:0]  hdr_idx;
    logic [3:0]  tid_k;
    logic [31:0] tid_word;
    logic [7:0]  hdr_expect;

    assign hdr_idx = count_reg[4:0];
    assign tid_k   = 4'(hdr_idx - 5'd8);

    always_comb
    begin
        if (tid_k < 4'd4)
            tid_word = txid_high_reg;
        else if (tid_k < 4'd8)
            tid_word = txid_mid_reg;
        else
            tid_word = txid_low_reg;

        if (hdr_idx < 5'd2)
            hdr_expect = smap_pkg::TYPE_BYTE;
        else if (hdr_idx < 5'd8)
            hdr_expect = smap_pkg::MAGIC_COOKIE[{~hdr_idx[1:0], 3'b000} +: 8];
        else
            hdr_expect = tid_word[{~tid_k[1:0], 3'b000} +: 8];
    end

    // Attribute walk helpers
    logic [PW-1:0] pos;
    logic [PW:0]   start_plus4;
    logic [PW:0]   body_end;
    logic          hdr_hit;
    logic [PW-1:0] hdr_off;
    logic [15:0]   len_full;
    logic [PW-1:0] len_round;
    logic          addr_attr;
    logic [PW-1:0] value_start;
    logic [PW-1:0] value_off;

    assign pos         = {1'b0, count_reg};
    assign start_plus4 = {1'b0, next_start_reg} + (PW+1)'(4);
    assign body_end    = (PW+1)'(smap_pkg::HEADER_BYTES) + {3'b000, msg_len_reg};
    assign hdr_hit     = !match_reg && (pos >= next_start_reg)
                         && ({1'b0, pos} < start_plus4) && (start_plus4 <= body_end);
    assign hdr_off     = pos - next_start_reg;
    assign len_full    = {attr_len_reg[15:8], rx_byte};
    assign len_round   = ({2'b00, len_full} + PW'(3)) & ~PW'(3);
    assign addr_attr   = (last_end_reg != '0) && (pos < next_start_reg)
                         && ((attr_type_reg == smap_pkg::ATTR_XOR_MAPPED)
                             || (attr_type_reg == smap_pkg::ATTR_XOR_MAPPED2))
                         && (attr_len_reg >= smap_pkg::MIN_ADDR_LEN);
    assign value_start = last_end_reg - {2'b00, attr_len_reg};
    assign value_off   = pos - value_start;

    // Next parse state for the byte on the input
    always_comb
    begin
        hdr_good_next   = hdr_good_reg;
        msg_len_next    = msg_len_reg;
        next_start_next = next_start_reg;
        attr_type_next  = attr_type_reg;
        attr_len_next   = attr_len_reg;
        last_end_next   = last_end_reg;
        match_next      = match_reg;
        family_next     = family_reg;
        port_next       = port_reg;
        addr_next       = addr_reg;

        if (count_reg < CW'(smap_pkg::HEADER_BYTES))
        begin
            // Fixed header: length field or byte compare
            if (hdr_idx == 5'd2)
                msg_len_next = {rx_byte, 8'h00};
            else if (hdr_idx == 5'd3)
                msg_len_next = {msg_len_reg[15:8], rx_byte};
            else if (rx_byte != hdr_expect)
                hdr_good_next = 1'b0;
        end
        else if (hdr_hit)
        begin
            // Attribute header: type and length
            unique case (hdr_off[1:0])
                2'd0: attr_type_next = {rx_byte, 8'h00};
                2'd1: attr_type_next = {attr_type_reg[15:8], rx_byte};
                2'd2: attr_len_next  = {rx_byte, 8'h00};
                2'd3:
                begin
                    attr_len_next   = len_full;
                    last_end_next   = start_plus4[PW-1:0] + {2'b00, len_full};
                    next_start_next = start_plus4[PW-1:0] + len_round;
                end
                default: ;
            endcase
        end
        else if (addr_attr && (pos >= value_start))
        begin
            // Mapped address value bytes
            if (value_off == PW'(1))
            begin
                family_next = rx_byte;
                if (rx_byte == smap_pkg::FAMILY_IPV4)
                    match_next = 1'b1;
            end
            else if ((value_off == PW'(2)) || (value_off == PW'(3)))
                port_next = {port_reg[7:0], rx_byte};
            else if ((value_off >= PW'(4)) && (value_off <= PW'(7)))
                addr_next = {addr_reg[23:0], rx_byte};
        end
    end

    // Saturating byte count
    assign count_next = (count_reg == smap_pkg::COUNT_MAX) ? count_reg
                                                          : count_reg + CW'(1);

    // Result decision on the last byte
    always_comb
    begin
        status_next   = smap_pkg::STATUS_NONE;
        map_addr_next = 32'd0;
        map_port_next = 16'd0;
        priority if ((count_next < CW'(smap_pkg::HEADER_BYTES)) || !hdr_good_next)
            status_next = smap_pkg::STATUS_HDR_REJECT;
        else if ((PW+1)'(smap_pkg::HEADER_BYTES) + {3'b000, msg_len_next}
                 > {2'b00, count_next})
            status_next = smap_pkg::STATUS_LEN_ERROR;
        else if (last_end_next > {1'b0, count_next})
            status_next = smap_pkg::STATUS_LEN_ERROR;
        else if (match_next)
        begin
            status_next   = smap_pkg::STATUS_FOUND;
            map_addr_next = addr_next ^ smap_pkg::MAGIC_COOKIE;
            map_port_next = port_next ^ smap_pkg::MAGIC_COOKIE[31:16];
        end
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            hdr_good_reg   <= 1'b1;
            msg_len_reg    <= '0;
            next_start_reg <= PW'(smap_pkg::HEADER_BYTES);
            attr_type_reg  <= '0;
            attr_len_reg   <= '0;
            last_end_reg   <= '0;
            match_reg      <= 1'b0;
            family_reg     <= '0;
            port_reg       <= '0;
            addr_reg       <= '0;
        end
        else if (rx_accept)
        begin
            if (last_flag)
            begin
                count_reg      <= '0;
                hdr_good_reg   <= 1'b1;
                msg_len_reg    <= '0;
                next_start_reg <= PW'(smap_pkg::HEADER_BYTES);
                attr_type_reg  <= '0;
                attr_len_reg   <= '0;
                last_end_reg   <= '0;
                match_reg      <= 1'b0;
                family_reg     <= '0;
                port_reg       <= '0;
                addr_reg       <= '0;
            end
            else
            begin
                count_reg      <= count_next;
                hdr_good_reg   <= hdr_good_next;
                msg_len_reg    <= msg_len_next;
                next_start_reg <= next_start_next;
                attr_type_reg  <= attr_type_next;
                attr_len_reg   <= attr_len_next;
                last_end_reg   <= last_end_next;
                match_reg      <= match_next;
                family_reg     <= family_next;
                port_reg       <= port_next;
                addr_reg       <= addr_next;
            end
        end
    end

    // Result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (rx_accept && last_flag)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rx_accept && last_flag)
        begin
            status_reg   <= status_next;
            map_addr_reg <= map_addr_next;
            map_port_reg <= map_port_next;
        end
    end

`ifndef SYNTHESIS
    // A last byte always produces a result beat next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        rx_accept && last_flag |=> res_valid)
        else $error("last byte did not produce a result beat");

    // The parser restarts after every packet
    assert property (@(posedge clk) disable iff (!rst_n)
        rx_accept && last_flag |=> (count_reg == '0) && !match_reg)
        else $error("parse state not cleared after last byte");

    // Endpoint fields are zero unless the address was found
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status != smap_pkg::STATUS_FOUND)
            |-> (mapped_address == 32'd0) && (mapped_port == 16'd0))
        else $error("endpoint fields set without a found status");

    // Attribute headers stay on 4-byte boundaries
    assert property (@(posedge clk) disable iff (!rst_n)
        next_start_reg[1:0] == 2'b00)
        else $error("attribute start misaligned");
`endif

endmodule

/* tb/stun_mapped_address_parser_test.sv */
`timescale 1ns / 1ps

// One decoded endpoint as the parser reports it
typedef struct packed {
    bit [1:0]  status;
    bit [31:0] address;
    bit [15:0] port;
} endpoint_t;

// Tracks the parse of each response byte by byte and holds the endpoints still owed
class endpoint_predictor;
    bit [31:0] txid [3];
    int        errors;
    endpoint_t expected_endpoints [$];

    // per-packet parse state
    bit [16:0] byte_count;
    bit        header_good;
    bit [15:0] msg_len;
    bit [17:0] next_start;
    bit [15:0] type_word;
    bit [15:0] len_word;
    bit [17:0] last_end;
    bit        matched;
    bit [7:0]  family;
    bit [15:0] port_word;
    bit [31:0] addr_word;

    function new();
        errors = 0;
        clear_packet();
    endfunction

    function void clear_packet();
        byte_count  = '0;
        header_good = 1'b1;
        msg_len     = '0;
        next_start  = 18'(smap_pkg::HEADER_BYTES);
        type_word   = '0;
        len_word    = '0;
        last_end    = '0;
        matched     = 1'b0;
        family      = '0;
        port_word   = '0;
        addr_word   = '0;
    endfunction

    function int pending();
        return expected_endpoints.size();
    endfunction

    // Accepted input beat
    function void take_byte(logic [7:0] b, logic is_last);
        int        i;
        int        start;
        int        k;
        int        vs;
        int        pkt_size;
        bit [7:0]  want;
        bit [31:0] w;
        endpoint_t r;

        i = int'(byte_count);
        if (i < smap_pkg::HEADER_BYTES) begin
            if (i == 2) begin
                msg_len = {b, 8'h00};
            end
            else if (i == 3) begin
                msg_len[7:0] = b;
            end
            else begin
                if (i < 2) begin
                    want = smap_pkg::TYPE_BYTE;
                end
                else if (i < 8) begin
                    want = smap_pkg::MAGIC_COOKIE[8 * (7 - i) +: 8];
                end
                else begin
                    k = i - 8;
                    w = txid[k / 4];
                    want = w[8 * (3 - k % 4) +: 8];
                end
                if (b != want) header_good = 1'b0;
            end
        end
        else begin
            start = int'(next_start);
            // attribute header, only while no match and inside the message
            if (!matched && i >= start && i < start + 4 &&
                start + 4 <= smap_pkg::HEADER_BYTES + int'(msg_len)) begin
                case (i - start)
                    0: type_word = {b, 8'h00};
                    1: type_word[7:0] = b;
                    2: len_word = {b, 8'h00};
                    default:
                    begin
                        len_word[7:0] = b;
                        last_end   = 18'(start + 4 + int'(len_word));
                        next_start = 18'(start + 4 + ((int'(len_word) + 3) & ~3));
                    end
                endcase
            end
            // value bytes of a mapped-address attribute
            else if (last_end != 0 && i < int'(next_start) &&
                     (type_word == smap_pkg::ATTR_XOR_MAPPED ||
                      type_word == smap_pkg::ATTR_XOR_MAPPED2) &&
                     len_word >= smap_pkg::MIN_ADDR_LEN) begin
                vs = int'(last_end) - int'(len_word);
                if (i >= vs) begin
                    k = i - vs;
                    if (k == 1) begin
                        family = b;
                        if (!matched && b == smap_pkg::FAMILY_IPV4) matched = 1'b1;
                    end
                    else if (k == 2 || k == 3) begin
                        port_word = {port_word[7:0], b};
                    end
                    else if (k >= 4 && k <= 7) begin
                        addr_word = {addr_word[23:0], b};
                    end
                end
            end
        end

        if (byte_count != smap_pkg::COUNT_MAX) byte_count = byte_count + 17'd1;

        if (is_last) begin
            pkt_size  = int'(byte_count);
            r.status  = smap_pkg::STATUS_NONE;
            r.address = '0;
            r.port    = '0;
            if (pkt_size < smap_pkg::HEADER_BYTES || !header_good) begin
                r.status = smap_pkg::STATUS_HDR_REJECT;
            end
            else if (smap_pkg::HEADER_BYTES + int'(msg_len) > pkt_size) begin
                r.status = smap_pkg::STATUS_LEN_ERROR;
            end
            else if (int'(last_end) > pkt_size) begin
                r.status = smap_pkg::STATUS_LEN_ERROR;
            end
            else if (matched) begin
                r.status  = smap_pkg::STATUS_FOUND;
                r.address = addr_word ^ smap_pkg::MAGIC_COOKIE;
                r.port    = port_word ^ smap_pkg::MAGIC_COOKIE[31:16];
            end
            expected_endpoints.insert(expected_endpoints.size(), r);
            clear_packet();
        end
    endfunction

    // Accepted result beat
    function void check_endpoint(logic [1:0] st, logic [31:0] addr, logic [15:0] port);
        endpoint_t r;
        if (expected_endpoints.size() == 0) begin
            $error("unexpected result beat: status %0d", st);
            errors++;
            return;
        end
        r = expected_endpoints.pop_front();
        if (st !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, st);
            errors++;
        end
        if (addr !== r.address) begin
            $error("mapped_address: expected %h, got %h", r.address, addr);
            errors++;
        end
        if (port !== r.port) begin
            $error("mapped_port: expected %h, got %h", r.port, port);
            errors++;
        end
    endfunction
endclass

module stun_mapped_address_parser_test;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        rx_valid = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        last_flag = 1'b0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [1:0]  status;
    logic [31:0] mapped_address;
    logic [15:0] mapped_port;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    int tx_idle_pct = 13;
    int rx_idle_pct = 85;
    int quiet_cycles = 0;

    endpoint_predictor endpoints = new();

    // packet under construction
    logic [7:0] pkt [$];

    stun_mapped_address_parser dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_valid       (rx_valid),
        .rx_stall       (rx_stall),
        .rx_byte        (rx_byte),
        .last_flag      (last_flag),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .status         (status),
        .mapped_address (mapped_address),
        .mapped_port    (mapped_port),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #2 clk = ~clk;

    // Result-side backpressure
    always @(posedge clk)
    begin
        res_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Sample both channels
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (rx_valid && !rx_stall) endpoints.take_byte(rx_byte, last_flag);
            if (res_valid && !res_stall)
                endpoints.check_endpoint(status, mapped_address, mapped_port);
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((rx_valid && !rx_stall) || (res_valid && !res_stall) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("stun_mapped_address_parser_test: FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] rand_octet();
        return 8'($urandom_range(0, 255));
    endfunction

    // Append one byte to the packet under construction
    function automatic void append_octet(input logic [7:0] b);
        pkt.insert(pkt.size(), b);
    endfunction

    function automatic void put_msg_len(input logic [15:0] len);
        pkt[2] = len[15:8];
        pkt[3] = len[7:0];
    endfunction

    function automatic void fit_msg_len();
        put_msg_len(16'(pkt.size() - smap_pkg::HEADER_BYTES));
    endfunction

    function automatic void cut_to(input int n);
        while (pkt.size() > n) void'(pkt.pop_back());
    endfunction

    function automatic void pad_random(input int n);
        while (pkt.size() < n) append_octet(rand_octet());
    endfunction

    // Header with the current transaction id
    function automatic void start_header(input logic [15:0] len);
        int w;
        int j;
        pkt.delete();
        append_octet(smap_pkg::TYPE_BYTE);
        append_octet(smap_pkg::TYPE_BYTE);
        append_octet(len[15:8]);
        append_octet(len[7:0]);
        for (j = 0; j < 4; j++) append_octet(smap_pkg::MAGIC_COOKIE[31 - 8 * j -: 8]);
        for (w = 0; w < 3; w++)
            for (j = 0; j < 4; j++) append_octet(endpoints.txid[w][31 - 8 * j -: 8]);
    endfunction

    // Attribute: reserved, family, port, address, then filler, padded to 4 bytes
    function automatic void add_attr(input logic [15:0] kind, input logic [15:0] len,
                                     input logic [7:0] fam, input logic [15:0] port_raw,
                                     input logic [31:0] addr_raw);
        logic [63:0] body;
        int          j;
        body = {rand_octet(), fam, port_raw, addr_raw};
        append_octet(kind[15:8]);
        append_octet(kind[7:0]);
        append_octet(len[15:8]);
        append_octet(len[7:0]);
        for (j = 0; j < int'(len); j++)
            append_octet(j < 8 ? body[63 - 8 * j -: 8] : rand_octet());
        for (j = int'(len); j % 4 != 0; j++) append_octet(rand_octet());
    endfunction

    function automatic logic [15:0] pick_kind(input int mapped_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < mapped_pct / 2) return smap_pkg::ATTR_XOR_MAPPED;
        if (r < mapped_pct) return smap_pkg::ATTR_XOR_MAPPED2;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic void build_random_packet();
        int          r;
        int          n;
        int          j;
        logic [15:0] len;
        logic [7:0]  fam;
        r = $urandom_range(0, 99);
        // pure noise
        if (r >= 92) begin
            pkt.delete();
            pad_random($urandom_range(1, 48));
            return;
        end
        start_header(16'h0000);
        n = $urandom_range(0, 3);
        for (j = 0; j < n; j++) begin
            case ($urandom_range(0, 3))
                0, 1: len = smap_pkg::MIN_ADDR_LEN;
                2: len = 16'd12;
                default: len = 16'($urandom_range(0, 15));
            endcase
            fam = ($urandom_range(0, 99) < 75) ? smap_pkg::FAMILY_IPV4 : rand_octet();
            add_attr(pick_kind(65), len, fam, 16'($urandom_range(0, 65535)), $urandom);
        end
        fit_msg_len();
        if ($urandom_range(0, 99) < 15) pad_random(pkt.size() + $urandom_range(1, 6));
        // unless r is below 60, break the packet in one of several ways
        if (r < 60) begin
        end
        else if (r < 68) begin
            if (pkt.size() > smap_pkg::HEADER_BYTES)
                cut_to($urandom_range(smap_pkg::HEADER_BYTES, pkt.size() - 1));
        end
        else if (r < 76) begin
            n = $urandom_range(0, 17);
            if (n >= 2) n += 2;
            pkt[n] = pkt[n] ^ (8'h01 << $urandom_range(0, 7));
        end
        else if (r < 84) begin
            if ($urandom_range(0, 1) == 0 || pkt.size() < 24)
                put_msg_len(16'($urandom_range(0, 65535)));
            else
                put_msg_len(16'(pkt.size() - 24 + $urandom_range(0, 8)));
        end
        else begin
            cut_to($urandom_range(1, smap_pkg::HEADER_BYTES - 1));
        end
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid  <= 1'b1;
        rx_byte   <= value;
        last_flag <= is_last;
        @(posedge clk);
        while (rx_stall) @(posedge clk);
    endtask

    task automatic send_packet();
        int j;
        for (j = 0; j < pkt.size(); j++) send_byte(pkt[j], j == pkt.size() - 1);
    endtask

    // Drop valid and let every owed endpoint come out
    task automatic wait_idle();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (endpoints.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        endpoints.txid[idx] = value;
        @(posedge clk);
    endtask

    task automatic set_txid(input logic [31:0] hi, input logic [31:0] mid,
                            input logic [31:0] lo);
        wait_idle();
        write_reg(smap_pkg::REG_TXID_HIGH, hi);
        write_reg(smap_pkg::REG_TXID_MID, mid);
        write_reg(smap_pkg::REG_TXID_LOW, lo);
    endtask

    initial
    begin : stimulus
        int phase;
        int phase_bytes;
        int phase_pkts;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_txid(32'hFFFF_FFFF, 32'h0000_0000, $urandom);

        // decoded endpoint all zeros
        start_header(16'h0000);
        add_attr(smap_pkg::ATTR_XOR_MAPPED, smap_pkg::MIN_ADDR_LEN, smap_pkg::FAMILY_IPV4,
                 smap_pkg::MAGIC_COOKIE[31:16], smap_pkg::MAGIC_COOKIE);
        fit_msg_len();
        send_packet();
        // decoded endpoint all ones, alternate attribute type
        start_header(16'h0000);
        add_attr(smap_pkg::ATTR_XOR_MAPPED2, smap_pkg::MIN_ADDR_LEN, smap_pkg::FAMILY_IPV4,
                 ~smap_pkg::MAGIC_COOKIE[31:16], ~smap_pkg::MAGIC_COOKIE);
        fit_msg_len();
        send_packet();
        // bare header, no attributes
        start_header(16'h0000);
        send_packet();
        // unrelated attribute only
        start_header(16'h0000);
        add_attr(16'h0001, smap_pkg::MIN_ADDR_LEN, smap_pkg::FAMILY_IPV4, 16'h1234,
                 32'h5566_7788);
        fit_msg_len();
        send_packet();
        // mapped attribute one byte too short
        start_header(16'h0000);
        add_attr(smap_pkg::ATTR_XOR_MAPPED, 16'd7, smap_pkg::FAMILY_IPV4, 16'h1234,
                 32'h5566_7788);
        fit_msg_len();
        send_packet();
        // IPv6 family skipped, later IPv4 taken
        start_header(16'h0000);
        add_attr(smap_pkg::ATTR_XOR_MAPPED, 16'd20, 8'h02, 16'hAAAA, 32'hBBBB_CCCC);
        add_attr(smap_pkg::ATTR_XOR_MAPPED2, smap_pkg::MIN_ADDR_LEN, smap_pkg::FAMILY_IPV4,
                 16'h0F0F, 32'hF0F0_0F0F);
        fit_msg_len();
        send_packet();
        // two IPv4 attributes, the first wins
        start_header(16'h0000);
        add_attr(smap_pkg::ATTR_XOR_MAPPED, 16'd12, smap_pkg::FAMILY_IPV4, 16'h1111,
                 32'h2222_3333);
        add_attr(smap_pkg::ATTR_XOR_MAPPED, smap_pkg::MIN_ADDR_LEN, smap_pkg::FAMILY_IPV4,
                 16'h4444, 32'h5555_6666);
        fit_msg_len();
        send_packet();
        // odd-length attribute padded ahead of the mapped one
        start_header(16'h0000);
        add_attr(16'h8022, 16'd5, 8'h00, 16'h0000, 32'h0);
        add_attr(smap_pkg::ATTR_XOR_MAPPED, smap_pkg::MIN_ADDR_LEN, smap_pkg::FAMILY_IPV4,
                 16'hBEEF, 32'hC0A8_0001);
        fit_msg_len();
        send_packet();
        // trailing bytes past the message length
        start_header(16'h0000);
        add_attr(smap_pkg::ATTR_XOR_MAPPED, smap_pkg::MIN_ADDR_LEN, smap_pkg::FAMILY_IPV4,
                 16'h7777, 32'h0A00_0001);
        fit_msg_len();
        pad_random(pkt.size() + 3);
        send_packet();
        // attribute header beyond message length is never read
        start_header(16'h0000);
        add_attr(smap_pkg::ATTR_XOR_MAPPED, smap_pkg::MIN_ADDR_LEN, smap_pkg::FAMILY_IPV4,
                 16'h7777, 32'h0A00_0001);
        put_msg_len(16'd2);
        send_packet();
        // walked attribute runs past the packet end
        start_header(16'h0000);
        add_attr(smap_pkg::ATTR_XOR_MAPPED, smap_pkg::MIN_ADDR_LEN, smap_pkg::FAMILY_IPV4,
                 16'h7777, 32'h0A00_0001);
        put_msg_len(16'd4);
        cut_to(28);
        send_packet();
        // matched attribute runs past the packet end
        start_header(16'h0000);
        add_attr(smap_pkg::ATTR_XOR_MAPPED, 16'd12, smap_pkg::FAMILY_IPV4, 16'h7777,
                 32'h0A00_0001);
        put_msg_len(16'd12);
        cut_to(32);
        send_packet();
        // message length just beyond the packet
        start_header(16'h0000);
        add_attr(smap_pkg::ATTR_XOR_MAPPED, smap_pkg::MIN_ADDR_LEN, smap_pkg::FAMILY_IPV4,
                 16'h7777, 32'h0A00_0001);
        put_msg_len(16'(pkt.size() - smap_pkg::HEADER_BYTES + 4));
        send_packet();
        // largest message length
        start_header(16'hFFFF);
        add_attr(smap_pkg::ATTR_XOR_MAPPED, smap_pkg::MIN_ADDR_LEN, smap_pkg::FAMILY_IPV4,
                 16'h7777, 32'h0A00_0001);
        send_packet();
        // wrong message type
        start_header(16'h0000);
        pkt[0] = 8'h00;
        send_packet();
        // wrong cookie byte
        start_header(16'h0000);
        pkt[5] = pkt[5] ^ 8'h80;
        send_packet();
        // wrong transaction id byte in each word
        start_header(16'h0000);
        pkt[8] = pkt[8] ^ 8'h01;
        send_packet();
        start_header(16'h0000);
        pkt[15] = pkt[15] ^ 8'h10;
        send_packet();
        start_header(16'h0000);
        pkt[19] = pkt[19] ^ 8'h80;
        send_packet();
        // single byte and one byte short of a header
        start_header(16'h0000);
        cut_to(1);
        send_packet();
        start_header(16'h0000);
        cut_to(smap_pkg::HEADER_BYTES - 1);
        send_packet();

        // Random packets in three backpressure phases
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: set_txid($urandom, $urandom, $urandom);
                1: set_txid(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
                default: set_txid(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            endcase
            tx_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 85 : 0;
            rx_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 13 : 0;
            phase_bytes = 0;
            phase_pkts  = 0;
            while (phase_bytes < 300 || phase_pkts < 8) begin
                build_random_packet();
                phase_bytes += pkt.size();
                phase_pkts++;
                send_packet();
            end
        end

        wait_idle();
        if (endpoints.errors == 0 && endpoints.pending() == 0)
            $display("stun_mapped_address_parser_test: PASS");
        else
            $display("stun_mapped_address_parser_test: FAIL");
        $finish;
    end

endmodule
